@@ design/erf_pkg.sv @@
// shared types and constants for the escaped frame receiver
// no dependencies; imported by escaped_frame_receiver
`default_nettype none

package erf_pkg;

    // byte width of every field and register
    localparam int unsigned BYTE_W = 8;
    // address, command, length and timestamp ahead of the payload
    localparam int unsigned HDR_BYTES = 8;
    // little-endian checksum at the end of the body
    localparam int unsigned SUM_BYTES = 2;
    localparam int unsigned MIN_BODY = HDR_BYTES + SUM_BYTES;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned EVENT_W = 3;
    localparam int unsigned OUT_DATA_W = 24;
    localparam int unsigned IN_DATA_W = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_FIRST  = 3'd0,
        CFG_HEADER_SECOND = 3'd1,
        CFG_TAIL_BYTE     = 3'd2,
        CFG_ESCAPE_BYTE   = 3'd3,
        CFG_ESCAPE_MASK   = 3'd4
    } cfg_idx_t;

    // result event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 3'd0,
        EV_FRAME_OK  = 3'd1,
        EV_TOO_SHORT = 3'd2,
        EV_LEN_BAD   = 3'd3,
        EV_SUM_BAD   = 3'd4,
        EV_OVERFLOW  = 3'd5
    } event_t;

    // hunt state, one-hot
    typedef enum logic [3:0] {
        ST_HUNT   = 4'b0001,
        ST_SEEN   = 4'b0010,
        ST_BODY   = 4'b0100,
        ST_ESCAPE = 4'b1000
    } hunt_t;

endpackage

`default_nettype wire

@@ design/escaped_frame_receiver.sv @@
// escaped frame receiver: header hunt, byte unstuffing, body store and frame check
// depends on erf_pkg
`default_nettype none

// Usage
// - slave stream: one item per transfer; tuser is kind (0 received byte, 1 payload read),
//   tdata carries rx_byte in [7:0] and read_index in [15:8]
// - master stream: exactly one result per input item, in order; tdata carries
//   event_res [2:0], payload length [10:3], read_data [18:11], zero above
// - config port: cfg_we writes cfg_wdata into register cfg_index (header_first,
//   header_second, tail_byte, escape_byte, escape_mask); only while the block is idle
// - throughput: one item per cycle sustained while the result stream accepts; the header
//   hunt, the checksum check and the body store write all finish in the cycle of the transfer
// - pipeline: each item passes the read stage and then the output register before tvalid
//   rises; the read stage is there for the registered read data of the body store
// - the checksum is tracked as a running sum lagging two bytes behind, with the last
//   two bytes and the length field kept in registers, so the frame check needs no
//   memory read at the tail byte
// - reset: hunt state, counters and configuration return to their defaults at once;
//   the body store keeps whatever it held and needs no clearing pass
// - stall: a held result stays in the output register while one more item sits in the
//   memory read stage; tready drops only when both are full
module escaped_frame_receiver #(
    parameter int unsigned BODY_DEPTH = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [erf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [erf_pkg::BYTE_W-1:0]        cfg_wdata,
    // input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [erf_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // rx_byte, read_index
    input  wire logic                              s_axis_tuser,  // kind
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [erf_pkg::OUT_DATA_W-1:0]         m_axis_tdata   // event_res, payload length,
                                                                  // read_data, zero pad
);

    import erf_pkg::*;

    localparam int unsigned AW = (BODY_DEPTH > 1) ? $clog2(BODY_DEPTH) : 1;
    localparam int unsigned CW = $clog2(BODY_DEPTH + 1);
    // read position 8 + read_index, wide enough for the depth and for the byte offset
    localparam int unsigned PW = ((AW > BYTE_W) ? AW : BYTE_W) + 1;
    localparam int unsigned LW = 2 * BYTE_W + 1;

    // configuration registers
    logic [BYTE_W-1:0] hdr1_reg, hdr2_reg, tail_reg, esc_reg, mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr1_reg <= 8'd170;
            hdr2_reg <= 8'd85;
            tail_reg <= 8'd13;
            esc_reg  <= 8'd125;
            mask_reg <= 8'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER_FIRST:  hdr1_reg <= cfg_wdata;
                CFG_HEADER_SECOND: hdr2_reg <= cfg_wdata;
                CFG_TAIL_BYTE:     tail_reg <= cfg_wdata;
                CFG_ESCAPE_BYTE:   esc_reg  <= cfg_wdata;
                CFG_ESCAPE_MASK:   mask_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // input fields
    logic              in_kind;
    logic [BYTE_W-1:0] in_byte;
    logic [BYTE_W-1:0] in_idx;
    logic              in_xfer;

    assign in_kind = s_axis_tuser;
    assign in_byte = s_axis_tdata[BYTE_W-1:0];
    assign in_idx  = s_axis_tdata[2*BYTE_W-1:BYTE_W];
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // frame state
    hunt_t             state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [15:0]       lag_reg, lag_next;       // sum of all body bytes but the last two
    logic [BYTE_W-1:0] prev_reg, prev_next;     // second to last body byte
    logic [BYTE_W-1:0] last_reg, last_next;     // last body byte
    logic [BYTE_W-1:0] len_lo_reg, len_lo_next;
    logic [BYTE_W-1:0] len_hi_reg, len_hi_next;

    // per-item decode
    logic              store_req;
    logic              store_ok;
    logic [BYTE_W-1:0] store_data;
    event_t            ev_now;
    logic [BYTE_W-1:0] plen_now;
    logic [15:0]       declared;
    logic [LW-1:0]     expect_len;

    assign declared   = {len_hi_reg, len_lo_reg};
    assign expect_len = LW'(declared) + LW'(MIN_BODY);
    assign store_ok   = (32'(count_reg) < BODY_DEPTH);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        lag_next    = lag_reg;
        prev_next   = prev_reg;
        last_next   = last_reg;
        len_lo_next = len_lo_reg;
        len_hi_next = len_hi_reg;
        store_req   = 1'b0;
        store_data  = in_byte;
        ev_now      = EV_NONE;
        plen_now    = '0;

        if (!in_kind)
        begin
            case (state_reg)
                ST_HUNT:
                begin
                    if (in_byte == hdr1_reg)
                        state_next = ST_SEEN;
                end
                ST_SEEN:
                begin
                    if (in_byte == hdr2_reg)
                    begin
                        state_next = ST_BODY;
                        count_next = '0;
                        lag_next   = '0;
                        prev_next  = '0;
                        last_next  = '0;
                    end
                    else if (in_byte != hdr1_reg)
                        state_next = ST_HUNT;
                end
                ST_BODY:
                begin
                    // escape wins over tail when both match
                    if (in_byte == esc_reg)
                        state_next = ST_ESCAPE;
                    else if (in_byte == tail_reg)
                    begin
                        state_next = ST_HUNT;
                        count_next = '0;
                        if (32'(count_reg) < MIN_BODY)
                            ev_now = EV_TOO_SHORT;
                        else if (LW'(count_reg) != expect_len)
                            ev_now = EV_LEN_BAD;
                        else if ({last_reg, prev_reg} != lag_reg)
                            ev_now = EV_SUM_BAD;
                        else
                        begin
                            ev_now   = EV_FRAME_OK;
                            plen_now = len_lo_reg;
                        end
                    end
                    else
                        store_req = 1'b1;
                end
                ST_ESCAPE:
                begin
                    store_req  = 1'b1;
                    store_data = in_byte ^ mask_reg;
                    state_next = ST_BODY;
                end
                default:
                    state_next = ST_HUNT;
            endcase

            if (store_req)
            begin
                if (store_ok)
                begin
                    count_next = count_reg + CW'(1);
                    lag_next   = lag_reg + 16'(prev_reg);
                    prev_next  = last_reg;
                    last_next  = store_data;
                    if (32'(count_reg) == 2)
                        len_lo_next = store_data;
                    if (32'(count_reg) == 3)
                        len_hi_next = store_data;
                end
                else
                begin
                    state_next = ST_HUNT;
                    ev_now     = EV_OVERFLOW;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_HUNT;
            count_reg  <= '0;
            lag_reg    <= '0;
            prev_reg   <= '0;
            last_reg   <= '0;
            len_lo_reg <= '0;
            len_hi_reg <= '0;
        end
        else if (in_xfer)
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            lag_reg    <= lag_next;
            prev_reg   <= prev_next;
            last_reg   <= last_next;
            len_lo_reg <= len_lo_next;
            len_hi_reg <= len_hi_next;
        end
    end

    // body store: one write port, one registered read port
    logic [BYTE_W-1:0] body_mem [BODY_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [PW-1:0]     rd_pos;
    logic              rd_in_range;
    logic              wr_en;
    logic              rd_en;

    assign rd_pos      = PW'(HDR_BYTES) + PW'(in_idx);
    assign rd_in_range = (32'(rd_pos) < BODY_DEPTH);
    assign wr_en       = in_xfer && store_req && store_ok;
    assign rd_en       = in_xfer && in_kind && rd_in_range;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            body_mem[count_reg[AW-1:0]] <= store_data;
        if (rd_en)
            rd_data_reg <= body_mem[rd_pos[AW-1:0]];
    end

    // read stage: item info waits here for the memory data
    logic              s1_valid_reg;
    logic              s1_read_reg;     // read item with a position inside the store
    event_t            s1_ev_reg;
    logic [BYTE_W-1:0] s1_plen_reg;
    logic              s1_move;

    // output register
    logic              out_valid_reg;
    event_t            out_ev_reg;
    logic [BYTE_W-1:0] out_plen_reg;
    logic [BYTE_W-1:0] out_rd_reg;

    assign s1_move       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_read_reg <= in_kind && rd_in_range;
            s1_ev_reg   <= ev_now;
            s1_plen_reg <= plen_now;
        end
        if (s1_move)
        begin
            out_ev_reg   <= s1_ev_reg;
            out_plen_reg <= s1_plen_reg;
            out_rd_reg   <= s1_read_reg ? rd_data_reg : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        (OUT_DATA_W - EVENT_W - 2 * BYTE_W)'(0),
        out_rd_reg,
        out_plen_reg,
        out_ev_reg
    };

`ifndef SYNTHESIS
    // a payload length is reported only with a good frame
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_plen_reg != '0) |-> (out_ev_reg == EV_FRAME_OK))
        else $error("payload length without good frame");

    // frame events come from received bytes, which never carry read data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_ev_reg != EV_NONE) |-> (out_rd_reg == '0))
        else $error("read data on a frame event");

    // the body count never passes the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= BODY_DEPTH)
        else $error("body count beyond store depth");

    // input stalls only when both the read stage and the output register are full
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled with room downstream");

    // a read item stuck in the read stage keeps its memory data
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_read_reg && !s1_move |=> $stable(rd_data_reg))
        else $error("read data lost during stall");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for escaped_frame_receiver: directed frames, error outcomes, register extremes
// and random traffic, each result transfer checked against an in-bench deframer model
// depends on erf_pkg and escaped_frame_receiver
`timescale 1ns / 100ps

module tb_top;

    import erf_pkg::*;

    localparam int unsigned CLK_PERIOD   = 10;
    localparam int unsigned STORE_DEPTH  = 256;
    localparam int unsigned RANDOM_ITEMS = 900;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_REPORTS  = 40;

    // result tdata layout
    localparam int unsigned EV_LSB  = 0;
    localparam int unsigned LEN_LSB = 3;
    localparam int unsigned RD_LSB  = 11;
    localparam int unsigned PAD_LSB = 19;

    // register values after reset
    localparam logic [7:0] RST_HEADER_FIRST  = 8'hAA;
    localparam logic [7:0] RST_HEADER_SECOND = 8'h55;
    localparam logic [7:0] RST_TAIL_BYTE     = 8'h0D;
    localparam logic [7:0] RST_ESCAPE_BYTE   = 8'h7D;
    localparam logic [7:0] RST_ESCAPE_MASK   = 8'h20;

    // hand-built stream under reset settings: noise, repeated first header, a zero-payload
    // frame holding header bytes, a stuffed escape and a raw tail after an escape, then a
    // one-byte body that is too short
    localparam int unsigned BASIC_LEN = 22;
    localparam logic [7:0] BASIC_SEQ [BASIC_LEN] = '{
        8'hFF, 8'h00, 8'hAA, 8'hAA, 8'h55,
        8'hAA, 8'h55, 8'h00, 8'h00, 8'h7D, 8'h5D, 8'h7D, 8'h0D, 8'hFF, 8'h00,
        8'hA8, 8'h02, 8'h0D,
        8'hAA, 8'h55, 8'h01, 8'h0D
    };

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_LEN,
        FR_SHORT,
        FR_OVERFLOW
    } frame_kind_t;

    typedef struct packed {
        event_t     ev;
        logic [7:0] plen;
        logic [7:0] rdata;
    } frame_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [BYTE_W-1:0]     cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // rx_byte, read_index
    logic                  s_axis_tuser;   // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // event_res, payload length, read_data, zero pad

    // model copy of the registers
    logic [7:0] hdr_first  = RST_HEADER_FIRST;
    logic [7:0] hdr_second = RST_HEADER_SECOND;
    logic [7:0] tail_val   = RST_TAIL_BYTE;
    logic [7:0] esc_val    = RST_ESCAPE_BYTE;
    logic [7:0] esc_mask   = RST_ESCAPE_MASK;

    // model copy of the deframer state
    hunt_t       rx_state = ST_HUNT;
    int unsigned fill_cnt = 0;
    logic [15:0] body_sum = '0;
    logic [7:0]  body_mem [STORE_DEPTH];
    bit          body_written [STORE_DEPTH];

    frame_result_t pending_results [$];

    int unsigned items_sent   = 0;
    int unsigned read_count   = 0;
    int unsigned config_count = 0;
    int unsigned mismatches   = 0;
    int unsigned ev_seen [8];
    int unsigned cycle_count  = 0;
    bit          in_burst     = 1'b0;
    bit          out_burst    = 1'b0;

    escaped_frame_receiver #(
        .BODY_DEPTH(STORE_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // hang guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                     cycle_count, pending_results.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // appends one body byte, false when the store is already full
    function automatic bit store_body_byte(input logic [7:0] val);
        if (fill_cnt >= STORE_DEPTH)
            return 1'b0;
        body_mem[fill_cnt] = val;
        body_written[fill_cnt] = 1'b1;
        fill_cnt++;
        body_sum = body_sum + val;
        return 1'b1;
    endfunction

    // advances the deframer model by one accepted input and queues the result it gives
    task automatic deframe_step(input logic kind, input logic [7:0] rx, input logic [7:0] ridx);
        frame_result_t res;
        int unsigned   pos;
        res.ev = EV_NONE;
        res.plen = '0;
        res.rdata = '0;
        if (kind)
        begin
            // reads leave every piece of state alone
            pos = HDR_BYTES + ridx;
            if (pos < STORE_DEPTH)
                res.rdata = body_mem[pos];
            read_count++;
        end
        else
        begin
            case (rx_state)
                ST_HUNT:
                begin
                    if (rx == hdr_first)
                        rx_state = ST_SEEN;
                end
                ST_SEEN:
                begin
                    // a repeated first header byte keeps waiting for the second
                    if (rx == hdr_second)
                    begin
                        rx_state = ST_BODY;
                        fill_cnt = 0;
                        body_sum = '0;
                    end
                    else if (rx != hdr_first)
                        rx_state = ST_HUNT;
                end
                ST_BODY:
                begin
                    // escape wins over tail when both registers match
                    if (rx == esc_val)
                        rx_state = ST_ESCAPE;
                    else if (rx == tail_val)
                    begin
                        if (fill_cnt < MIN_BODY)
                            res.ev = EV_TOO_SHORT;
                        else if (fill_cnt != MIN_BODY + {body_mem[3], body_mem[2]})
                            res.ev = EV_LEN_BAD;
                        else if ({body_mem[fill_cnt-1], body_mem[fill_cnt-2]} !=
                                 16'(body_sum - body_mem[fill_cnt-2] - body_mem[fill_cnt-1]))
                            res.ev = EV_SUM_BAD;
                        else
                        begin
                            res.ev = EV_FRAME_OK;
                            res.plen = body_mem[2];
                        end
                        rx_state = ST_HUNT;
                        fill_cnt = 0;
                    end
                    else if (!store_body_byte(rx))
                    begin
                        rx_state = ST_HUNT;
                        res.ev = EV_OVERFLOW;
                    end
                end
                default:
                begin
                    // byte after an escape is data, even a tail
                    if (store_body_byte(rx ^ esc_mask))
                        rx_state = ST_BODY;
                    else
                    begin
                        rx_state = ST_HUNT;
                        res.ev = EV_OVERFLOW;
                    end
                end
            endcase
        end
        ev_seen[res.ev]++;
        pending_results.push_back(res);
    endtask

    // one input transfer; returns at the falling edge after it with tvalid still high
    task automatic send_item(input logic kind, input logic [7:0] rx, input logic [7:0] ridx);
        int unsigned gap;
        gap = in_burst ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = kind;
        s_axis_tdata = {ridx, rx};
        deframe_step(kind, rx, ridx);
        items_sent++;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] rx);
        send_item(1'b0, rx, 8'($urandom));
    endtask

    task automatic send_read(input logic [7:0] ridx);
        send_item(1'b1, 8'($urandom), ridx);
    endtask

    // payload offset whose store entry has been written, or one whose position lies past the end of the store
    function automatic logic [7:0] pick_read_index();
        logic [7:0]  idx;
        int unsigned pos;
        for (int t = 0; t < 8; t++)
        begin
            idx = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31)) : 8'($urandom);
            pos = HDR_BYTES + idx;
            if (pos >= STORE_DEPTH || body_written[pos])
                return idx;
        end
        return 8'(STORE_DEPTH - HDR_BYTES + $urandom_range(0, HDR_BYTES - 1));
    endfunction

    // builds a body of the given flavor, stuffs it and sends it between header and tail
    task automatic send_frame(input frame_kind_t fk, input int unsigned plen);
        logic [7:0]  body [$];
        logic [15:0] sum;
        logic [15:0] declared;
        int unsigned n;
        // close any frame left open so the header is seen as a header
        if (rx_state == ST_ESCAPE)
            send_byte(8'($urandom));
        if (rx_state == ST_BODY && tail_val != esc_val)
            send_byte(tail_val);
        send_byte(hdr_first);
        send_byte(hdr_second);
        case (fk)
            FR_SHORT:
            begin
                n = $urandom_range(0, MIN_BODY - 1);
                repeat (n)
                    body.push_back(8'($urandom));
            end
            FR_OVERFLOW:
            begin
                repeat (STORE_DEPTH + 1)
                    body.push_back(8'($urandom));
            end
            default:
            begin
                declared = 16'(plen);
                if (fk == FR_BAD_LEN)
                begin
                    while (declared == 16'(plen))
                        declared = 16'($urandom);
                end
                body.push_back(8'($urandom));
                body.push_back(8'($urandom));
                body.push_back(declared[7:0]);
                body.push_back(declared[15:8]);
                repeat (4 + plen)
                    body.push_back(8'($urandom));
                sum = '0;
                foreach (body[i])
                    sum = sum + body[i];
                if (fk == FR_BAD_SUM)
                    sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
                body.push_back(sum[7:0]);
                body.push_back(sum[15:8]);
            end
        endcase
        foreach (body[i])
        begin
            // reads slipped into the middle of a frame must not disturb it
            if ($urandom_range(0, 15) == 0)
                send_read(pick_read_index());
            // stuff marker bytes, and now and then an ordinary one
            if (body[i] == esc_val || body[i] == tail_val || $urandom_range(0, 15) == 0)
            begin
                send_byte(esc_val);
                send_byte(body[i] ^ esc_mask);
            end
            else
                send_byte(body[i]);
        end
        if (fk != FR_OVERFLOW)
            send_byte(tail_val);
    endtask

    // stop the stream and let every expected result come back
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_HEADER_FIRST:  hdr_first = val;
            CFG_HEADER_SECOND: hdr_second = val;
            CFG_TAIL_BYTE:     tail_val = val;
            CFG_ESCAPE_BYTE:   esc_val = val;
            default:           esc_mask = val;
        endcase
    endtask

    task automatic set_config(input logic [7:0] hf, input logic [7:0] hs, input logic [7:0] tl,
                              input logic [7:0] es, input logic [7:0] mk);
        wait_idle();
        write_reg(CFG_HEADER_FIRST, hf);
        write_reg(CFG_HEADER_SECOND, hs);
        write_reg(CFG_TAIL_BYTE, tl);
        write_reg(CFG_ESCAPE_BYTE, es);
        write_reg(CFG_ESCAPE_MASK, mk);
        config_count++;
    endtask

    // hand-built frames under reset settings, then reads of what they left in the store
    task automatic test_basic_sequence();
        foreach (BASIC_SEQ[i])
            send_byte(BASIC_SEQ[i]);
        send_read(8'd0);
        send_read(8'd1);
        send_read(8'hFF);
    endtask

    // one frame of each outcome, including the largest payload that fits the store
    task automatic test_frame_outcomes();
        send_frame(FR_GOOD, 3);
        send_frame(FR_BAD_SUM, 5);
        send_frame(FR_BAD_LEN, 2);
        send_frame(FR_SHORT, 0);
        send_frame(FR_GOOD, STORE_DEPTH - MIN_BODY);
        send_read(8'(STORE_DEPTH - MIN_BODY - 1));
        send_frame(FR_OVERFLOW, 0);
        send_frame(FR_GOOD, 0);
    endtask

    // escape and tail share a value: that byte always escapes, only overflow ends the frame
    task automatic test_escape_as_tail();
        set_config(RST_HEADER_FIRST, RST_HEADER_SECOND, RST_TAIL_BYTE, RST_TAIL_BYTE,
                   RST_ESCAPE_MASK);
        send_byte(hdr_first);
        send_byte(hdr_second);
        repeat (4)
            send_byte(tail_val);
        send_frame(FR_OVERFLOW, 0);
    endtask

    // all-zero and all-one register corners
    task automatic test_config_extremes();
        set_config(8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF);
        send_frame(FR_GOOD, 4);
        send_frame(FR_BAD_SUM, 1);
        send_frame(FR_SHORT, 0);
        send_frame(FR_GOOD, 0);
        set_config(8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_frame(FR_GOOD, 6);
        send_frame(FR_BAD_LEN, 3);
        send_frame(FR_GOOD, 1);
        send_read(pick_read_index());
    endtask

    // phases of random settings, flow control and frame mix
    task automatic test_random_traffic();
        int unsigned start_items;
        int unsigned phase_end;
        int unsigned r;
        int unsigned plen;
        logic [7:0]  hf, hs, tl, es, mk;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
                set_config(RST_HEADER_FIRST, RST_HEADER_SECOND, RST_TAIL_BYTE,
                           RST_ESCAPE_BYTE, RST_ESCAPE_MASK);
            else
            begin
                hf = 8'($urandom);
                hs = ($urandom_range(0, 7) == 0) ? hf : 8'($urandom);
                tl = 8'($urandom);
                do
                    es = 8'($urandom);
                while (es == tl);
                mk = 8'($urandom);
                set_config(hf, hs, tl, es, mk);
            end
            in_burst = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            phase_end = items_sent + $urandom_range(120, 320);
            while (items_sent < phase_end)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    plen = STORE_DEPTH - MIN_BODY;
                else if (r < 10)
                    plen = $urandom_range(25, 120);
                else
                    plen = $urandom_range(0, 24);
                r = $urandom_range(0, 99);
                if (r < 6)
                    send_read(pick_read_index());
                else if (r < 12)
                begin
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom));
                end
                else if (r < 14)
                    send_frame(FR_OVERFLOW, 0);
                else if (r < 24)
                    send_frame(FR_SHORT, 0);
                else if (r < 32)
                    send_frame(FR_BAD_LEN, plen);
                else if (r < 42)
                    send_frame(FR_BAD_SUM, plen);
                else
                    send_frame(FR_GOOD, plen);
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endfunction

    // result side: random stalls, each result transfer checked in order
    initial
    begin : result_checker
        frame_result_t want;
        int unsigned   stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = out_burst ? 0 : $urandom_range(0, 9);
            if (stall != 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result transfer, expected none, got tdata %h",
                             $time, m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("event_res", 8'(want.ev), 8'(m_axis_tdata[EV_LSB +: EVENT_W]));
                check_field("payload length", want.plen, m_axis_tdata[LEN_LSB +: BYTE_W]);
                check_field("read_data", want.rdata, m_axis_tdata[RD_LSB +: BYTE_W]);
                check_field("tdata pad", 8'd0, 8'(m_axis_tdata[OUT_DATA_W-1:PAD_LSB]));
            end
        end
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_HEADER_FIRST;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_basic_sequence();
        test_frame_outcomes();
        test_escape_as_tail();
        test_config_extremes();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end
        $display("covered %0d input transfers over %0d register settings, %0d payload reads",
                 items_sent, config_count + 1, read_count);
        $display("frames: %0d ok, %0d short, %0d bad length, %0d bad checksum, %0d overflow",
                 ev_seen[EV_FRAME_OK], ev_seen[EV_TOO_SHORT], ev_seen[EV_LEN_BAD],
                 ev_seen[EV_SUM_BAD], ev_seen[EV_OVERFLOW]);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
